### rtl/hbe_pkg.sv
package hbe_pkg;

    // Palette geometry
    localparam int PALETTE_ENTRIES = 16;
    localparam int PAL_AW          = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int COLOR_W         = 24;

    // Item commands
    localparam logic [1:0] CMD_CELL = 2'd0;
    localparam logic [1:0] CMD_ROW  = 2'd1;
    localparam logic [1:0] CMD_PAL  = 2'd2;

    // What closes the byte run of an item
    localparam logic [1:0] TAIL_UPPER = 2'd0;
    localparam logic [1:0] TAIL_LOWER = 2'd1;
    localparam logic [1:0] TAIL_SPACE = 2'd2;
    localparam logic [1:0] TAIL_NL    = 2'd3;

    // Byte plan for one item, handed from the decoder to the sequencer
    typedef struct packed {
        logic       has_job;
        logic       need_rst;
        logic       fg_esc;
        logic       bg_esc;
        logic       fg_black;
        logic       bg_black;
        logic [1:0] tail;
    } t_plan;

    function automatic logic idx_in_range(logic [3:0] idx);
        return {1'b0, idx} < 5'(PALETTE_ENTRIES);
    endfunction

endpackage

### rtl/hbe_ram.sv
module hbe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic                                        i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/hbe_plan.sv
module hbe_plan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [1:0]    i_cmd,
    input  logic [3:0]    i_upper,
    input  logic [3:0]    i_lower,
    input  logic [3:0]    i_entry,
    output hbe_pkg::t_plan o_plan,
    output logic [3:0]    o_fg_idx,
    output logic [3:0]    o_bg_idx,
    output logic          o_pal_we
);
    import hbe_pkg::*;

    logic [3:0] r_fg, r_bg;
    logic [3:0] n_fg, n_bg;
    logic [1:0] keep_swapped, keep_straight;
    logic       swap;
    logic [3:0] lone_idx, fg_after_rst;
    t_plan      plan;

    always_comb begin
        n_fg          = r_fg;
        n_bg          = r_bg;
        plan          = '0;
        keep_swapped  = 2'(r_bg == i_upper) + 2'(r_fg == i_lower);
        keep_straight = 2'(r_fg == i_upper) + 2'(r_bg == i_lower);
        swap          = keep_swapped > keep_straight;
        lone_idx      = (i_upper != 4'd0) ? i_upper : i_lower;
        fg_after_rst  = (r_bg != 4'd0) ? 4'd0 : r_fg;
        unique case (i_cmd)
            CMD_CELL: begin
                plan.has_job = 1'b1;
                if (i_upper != 4'd0 && i_lower != 4'd0) begin
                    n_fg        = swap ? i_lower : i_upper;
                    n_bg        = swap ? i_upper : i_lower;
                    plan.fg_esc = r_fg != n_fg;
                    plan.bg_esc = r_bg != n_bg;
                    plan.tail   = swap ? TAIL_LOWER : TAIL_UPPER;
                end else if (i_upper != 4'd0 || i_lower != 4'd0) begin
                    // lone pixel: drop a set background first
                    plan.need_rst = r_bg != 4'd0;
                    n_fg          = lone_idx;
                    n_bg          = 4'd0;
                    plan.fg_esc   = fg_after_rst != lone_idx;
                    plan.tail     = (i_upper == 4'd0) ? TAIL_LOWER : TAIL_UPPER;
                end else begin
                    plan.need_rst = r_fg != 4'd0 || r_bg != 4'd0;
                    n_fg          = 4'd0;
                    n_bg          = 4'd0;
                    plan.tail     = TAIL_SPACE;
                end
            end
            CMD_ROW: begin
                plan.has_job  = 1'b1;
                plan.need_rst = r_fg != 4'd0 || r_bg != 4'd0;
                n_fg          = 4'd0;
                n_bg          = 4'd0;
                plan.tail     = TAIL_NL;
            end
            default: begin
            end
        endcase
        plan.fg_black = !idx_in_range(n_fg);
        plan.bg_black = !idx_in_range(n_bg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= 4'd0;
            r_bg <= 4'd0;
        end else if (i_accept) begin
            r_fg <= n_fg;
            r_bg <= n_bg;
        end
    end

    assign o_plan   = plan;
    assign o_fg_idx = n_fg;
    assign o_bg_idx = n_bg;
    assign o_pal_we = i_accept && i_cmd == CMD_PAL && idx_in_range(i_entry);

endmodule

### rtl/hbe_seq.sv
module hbe_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  hbe_pkg::t_plan                  i_plan,
    input  logic [hbe_pkg::COLOR_W-1:0]     i_fg_color,
    input  logic [hbe_pkg::COLOR_W-1:0]     i_bg_color,
    output logic                            o_ready,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [7:0]                      o_m_tdata,
    output logic                            o_m_tlast
);
    import hbe_pkg::*;

    localparam logic [1:0] PH_RST  = 2'd0;
    localparam logic [1:0] PH_FG   = 2'd1;
    localparam logic [1:0] PH_BG   = 2'd2;
    localparam logic [1:0] PH_TAIL = 2'd3;

    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [4:0] ESC_LAST = 5'd18;

    function automatic logic [1:0] phase_after(logic [1:0] ph, t_plan p);
        logic [1:0] nx;
        unique case (ph)
            PH_RST:  nx = p.fg_esc ? PH_FG : (p.bg_esc ? PH_BG : PH_TAIL);
            PH_FG:   nx = p.bg_esc ? PH_BG : PH_TAIL;
            PH_BG:   nx = PH_TAIL;
            default: nx = PH_TAIL;
        endcase
        return nx;
    endfunction

    // One decimal digit of an 8-bit value: 0 hundreds, 1 tens, 2 ones
    function automatic logic [3:0] dec_digit(logic [7:0] v, logic [1:0] sel);
        logic [1:0]  h;
        logic [7:0]  r8;
        logic [14:0] prod;
        logic [3:0]  t;
        logic [6:0]  o7;
        logic [3:0]  d;
        h    = (v >= 8'd200) ? 2'd2 : ((v >= 8'd100) ? 2'd1 : 2'd0);
        r8   = v - ((h == 2'd2) ? 8'd200 : ((h == 2'd1) ? 8'd100 : 8'd0));
        prod = 15'(r8[6:0]) * 15'd205;
        t    = prod[14:11];
        o7   = r8[6:0] - 7'(t) * 7'd10;
        case (sel)
            2'd0:    d = {2'b00, h};
            2'd1:    d = t;
            default: d = o7[3:0];
        endcase
        return d;
    endfunction

    logic        r_busy, r_out_valid;
    logic [1:0]  r_phase;
    logic [4:0]  r_pos;
    t_plan       r_job;
    logic [7:0]  r_out_byte;
    logic        r_out_last;

    logic        step, load, phase_end, tail_end;
    logic [7:0]  cur_byte, comp;
    logic [4:0]  doff;
    logic [23:0] color;
    logic        glyph;

    always_comb begin
        step  = r_busy && (!r_out_valid || i_m_tready);
        load  = i_accept && i_plan.has_job;
        color = (r_phase == PH_FG) ? (r_job.fg_black ? '0 : i_fg_color)
                                   : (r_job.bg_black ? '0 : i_bg_color);
        glyph = r_job.tail == TAIL_UPPER || r_job.tail == TAIL_LOWER;
        if (r_pos < 5'd11) begin
            comp = color[23:16];
            doff = r_pos - 5'd7;
        end else if (r_pos < 5'd15) begin
            comp = color[15:8];
            doff = r_pos - 5'd11;
        end else begin
            comp = color[7:0];
            doff = r_pos - 5'd15;
        end
        cur_byte  = 8'h00;
        phase_end = 1'b0;
        tail_end  = 1'b0;
        unique case (r_phase)
            PH_RST: begin
                phase_end = r_pos == 5'd2;
                case (r_pos)
                    5'd0:    cur_byte = CH_ESC;
                    5'd1:    cur_byte = "[";
                    default: cur_byte = "m";
                endcase
            end
            PH_FG, PH_BG: begin
                phase_end = r_pos == ESC_LAST;
                case (r_pos) inside
                    5'd0:                      cur_byte = CH_ESC;
                    5'd1:                      cur_byte = "[";
                    5'd2:                      cur_byte = (r_phase == PH_FG) ? "3" : "4";
                    5'd3:                      cur_byte = "8";
                    5'd4, 5'd6, 5'd10, 5'd14:  cur_byte = ";";
                    5'd5:                      cur_byte = "2";
                    ESC_LAST:                  cur_byte = "m";
                    default:                   cur_byte = 8'h30 + {4'h0, dec_digit(comp, doff[1:0])};
                endcase
            end
            default: begin
                phase_end = glyph ? (r_pos == 5'd2) : 1'b1;
                tail_end  = phase_end;
                case (r_job.tail)
                    TAIL_SPACE: cur_byte = " ";
                    TAIL_NL:    cur_byte = 8'h0A;
                    default: begin
                        case (r_pos)
                            5'd0:    cur_byte = 8'hE2;
                            5'd1:    cur_byte = 8'h96;
                            default: cur_byte = (r_job.tail == TAIL_LOWER) ? 8'h84 : 8'h80;
                        endcase
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= PH_RST;
            r_pos       <= 5'd0;
        end else begin
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (load) begin
                r_busy  <= 1'b1;
                r_phase <= i_plan.need_rst ? PH_RST : phase_after(PH_RST, i_plan);
                r_pos   <= 5'd0;
            end else if (step) begin
                if (tail_end) begin
                    r_busy <= 1'b0;
                end else if (phase_end) begin
                    r_phase <= phase_after(r_phase, r_job);
                    r_pos   <= 5'd0;
                end else begin
                    r_pos <= r_pos + 5'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_job <= i_plan;
        end
        if (step) begin
            r_out_byte <= cur_byte;
            r_out_last <= tail_end;
        end
    end

    assign o_ready    = !r_busy || (step && tail_end);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> r_busy && r_pos == 5'd0)
        else $error("job load did not start the sequencer");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_out_valid && !i_m_tready) |=> $stable(r_phase) && $stable(r_pos))
        else $error("sequencer advanced during output stall");

    a_rst_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_phase == PH_RST) |-> r_pos <= 5'd2)
        else $error("reset escape overran");

    a_esc_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_phase == PH_FG || r_phase == PH_BG)) |-> r_pos <= ESC_LAST)
        else $error("color escape overran");

endmodule

### rtl/half_block_ansi_cell_encoder.sv
// Channel   Dir  tdata (low bit up)                              tuser / tlast
// s_axis    in   upper[3:0] lower[7:4] entry[11:8] red[19:12]    tuser[1:0] = cmd
//                green[27:20] blue[35:28] zero pad to 40 bits
// m_axis    out  out_byte[7:0]                                   tlast = last byte of item
//
// One byte leaves per cycle from a single output register while m_axis is not stalled.
// An item is 1 byte for a space or newline, 4 with a reset ahead, 3 to 25 for a lone
// pixel, 3 to 41 for a colored pair; a palette write or an ignored cmd yields no byte.
// The byte sequencer sets those bytes; the next item is taken in the cycle the last byte
// of the current one moves into the output register. A stalled m_axis holds both.
// Reset clears the current colors and the sequencer; palette entries are not cleared.
module half_block_ansi_cell_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // upper, lower, entry, red, green, blue, pad
    input  logic [1:0]  s_axis_tuser,   // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic        m_axis_tlast
);
    import hbe_pkg::*;

    logic                accept;
    logic                pal_we;
    t_plan               plan;
    logic [3:0]          fg_idx, bg_idx;
    logic [COLOR_W-1:0]  fg_color, bg_color;
    logic [COLOR_W-1:0]  wr_color;
    logic                rd_en;

    // a beat moves when both sides agree
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign rd_en    = accept && plan.has_job;
    // palette words are stored red high, blue low
    assign wr_color = {s_axis_tdata[19:12], s_axis_tdata[27:20], s_axis_tdata[35:28]};

    // decode the cell against the current colors and advance them
    hbe_plan u_plan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_cmd    (s_axis_tuser),
        .i_upper  (s_axis_tdata[3:0]),
        .i_lower  (s_axis_tdata[7:4]),
        .i_entry  (s_axis_tdata[11:8]),
        .o_plan   (plan),
        .o_fg_idx (fg_idx),
        .o_bg_idx (bg_idx),
        .o_pal_we (pal_we)
    );

    // two copies of the palette so both escape colors are fetched on accept;
    // the read data holds for the life of the job
    hbe_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_pal_fg (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (s_axis_tdata[8 +: PAL_AW]),
        .i_wdata (wr_color),
        .i_re    (rd_en),
        .i_raddr (fg_idx[PAL_AW-1:0]),
        .o_rdata (fg_color)
    );

    hbe_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_ENTRIES)
    ) u_pal_bg (
        .i_clk   (i_clk),
        .i_we    (pal_we),
        .i_waddr (s_axis_tdata[8 +: PAL_AW]),
        .i_wdata (wr_color),
        .i_re    (rd_en),
        .i_raddr (bg_idx[PAL_AW-1:0]),
        .o_rdata (bg_color)
    );

    // walk reset, fg, bg and tail bytes out one beat per cycle unless m_axis stalls
    hbe_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_plan     (plan),
        .i_fg_color (fg_color),
        .i_bg_color (bg_color),
        .o_ready    (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_m_tdata  (m_axis_tdata),
        .o_m_tlast  (m_axis_tlast)
    );

endmodule
